// ===== rtl/core/audio_matrix_mixer_defines.svh =====
// Assertion macros used by the checker file.
`ifndef AUDIO_MATRIX_MIXER_DEFINES_SVH
`define AUDIO_MATRIX_MIXER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define AMM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("audio matrix mixer check failed");

// Consequent checked in the cycle after the antecedent.
`define AMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("audio matrix mixer check failed");

`endif

// ===== rtl/core/amm_pkg.sv =====
package amm_pkg;

	localparam int CH_IDX_W = 6;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_SAMPLE = 2'd1;
	localparam logic [1:0] MODE_SWAP   = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_LD
	} amm_state_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [3:0]         in_channel;
		logic [3:0]         out_channel;
		logic signed [31:0] gain;
		logic signed [31:0] sample;
		logic               end_of_frame;
	} amm_in_t;

	typedef struct packed {
		logic [3:0]         channel;
		logic signed [31:0] mixed;
		logic               last;
	} amm_out_t;

	typedef struct packed {
		logic                vld;
		logic                path_ok;
		logic [CH_IDX_W-1:0] idx;
	} amm_mac_req_t;

	typedef struct packed {
		logic                en;
		logic [CH_IDX_W-1:0] idx;
		logic signed [31:0]  data;
	} amm_acc_wr_t;

endpackage

// ===== rtl/core/amm_stream_if.sv =====
interface amm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/amm_mac.sv =====
module amm_mac #(
	parameter int GAIN_FRAC_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  amm_pkg::amm_mac_req_t req_s1,
	input  logic signed [31:0]    sample,
	input  logic signed [31:0]    gain_s1,
	input  logic signed [31:0]    acc_s1,
	output amm_pkg::amm_acc_wr_t  wr,
	output logic                  busy
);
	localparam logic [63:0] FRAC_MASK = (64'd1 << GAIN_FRAC_BITS) - 64'd1;
	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

	logic                         vld_s2, vld_s3;
	logic                         hit_s2, hit_s3;
	logic [amm_pkg::CH_IDX_W-1:0] idx_s2, idx_s3;
	logic signed [63:0]           prod_s2;
	logic signed [31:0]           acc_s2;
	logic signed [63:0]           sum_s3;
	logic signed [63:0]           q_floor;
	logic                         round_up;
	logic signed [63:0]           q_trunc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			hit_s2 <= 1'b0;
			hit_s3 <= 1'b0;
		end else begin
			vld_s2 <= req_s1.vld;
			hit_s2 <= req_s1.vld && req_s1.path_ok && (gain_s1 != 32'sd0);
			vld_s3 <= vld_s2;
			hit_s3 <= hit_s2;
		end
	end

	// Multiply stage, then the wide sum with the accumulator lined up on the binary point.
	always_ff @(posedge clk) begin
		prod_s2 <= 64'(sample) * 64'(gain_s1);
		acc_s2  <= acc_s1;
		idx_s2  <= req_s1.idx;
		sum_s3  <= (64'(acc_s2) <<< GAIN_FRAC_BITS) + prod_s2;
		idx_s3  <= idx_s2;
	end

	// Truncate toward zero: bump a negative floor up when fraction bits are lost.
	always_comb begin
		q_floor  = sum_s3 >>> GAIN_FRAC_BITS;
		round_up = sum_s3[63] && ((sum_s3 & FRAC_MASK) != 64'd0);
		q_trunc  = q_floor + $signed({63'd0, round_up});
		wr.en    = hit_s3;
		wr.idx   = idx_s3;
		if (q_trunc > SAT_MAX) begin
			wr.data = 32'sh7FFF_FFFF;
		end else if (q_trunc < SAT_MIN) begin
			wr.data = 32'sh8000_0000;
		end else begin
			wr.data = q_trunc[31:0];
		end
	end

	assign busy = vld_s2 || vld_s3;

endmodule

// ===== rtl/core/audio_matrix_mixer.sv =====
// Matrix mixer: folds input channel samples into output channel sums through a
// double-buffered Q(32-F).F gain matrix.
// Channels: req (sink) takes one request per valid/ready handshake; its mode picks
// a coefficient load into the shadow bank, a bank swap, or one input sample.
// mix (source) delivers one mixed sample per output channel at end of frame,
// channels in ascending order, last set on the final one.
// Flow: load and swap are applied as they are accepted. A sample request walks
// every output column through one shared multiply-accumulate pipeline, one
// column per cycle, via the registered gain/accumulator reads and MAC stages
// s2 and s3, then drains the pipe before req is ready again. An end-of-frame
// request then emits OUT_CHANNELS results, each read and then loaded into the
// result register once it is free, clearing each accumulator as it leaves.
// Reset: a clearing pass over all 2^(1 + clog2(IN) + clog2(OUT)) gain entries
// (512 at the defaults) writes unity on the diagonal of bank 0, zeros elsewhere,
// and clears the accumulators; req.ready stays low during the pass.
// Stall: the result register holds its value while mix.ready is low; emission
// waits on it, and a new request may be taken while the final result waits.
module audio_matrix_mixer #(
	parameter int IN_CHANNELS    = 16,
	parameter int OUT_CHANNELS   = 16,
	parameter int GAIN_FRAC_BITS = 24
) (
	input logic          clk,
	input logic          arst_n,
	amm_stream_if.sink   req,
	amm_stream_if.source mix
);
	localparam int IW        = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
	localparam int OW        = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
	localparam int XW        = (IW > OW) ? IW : OW;
	localparam int AW        = 1 + IW + OW;
	localparam int GDEPTH    = 1 << AW;
	localparam int ADEPTH    = 1 << OW;
	localparam logic [OW-1:0] LAST_J = OW'(OUT_CHANNELS - 1);
	localparam logic signed [31:0] UNITY = 32'sd1 <<< GAIN_FRAC_BITS;

	amm_pkg::amm_state_t   state_q, state_d;
	logic [AW-1:0]         clr_cnt_q;
	logic [OW-1:0]         j_q;
	logic                  bank_q;
	logic signed [31:0]    sample_q;
	logic [IW-1:0]         ic_q;
	logic                  ic_ok_q;
	logic                  eof_q;

	logic signed [31:0]    gain_mem [GDEPTH];
	logic signed [31:0]    acc_mem [ADEPTH];
	logic signed [31:0]    gain_rd_s1;
	logic signed [31:0]    acc_rd_s1;
	amm_pkg::amm_mac_req_t mac_req_s1;

	amm_pkg::amm_acc_wr_t  acc_wr;
	logic                  mac_busy;

	logic                  out_vld_q;
	amm_pkg::amm_out_t     out_q;

	logic                  accept;
	logic                  in_ok, out_ok;
	logic                  issue;
	logic                  emit_load;
	logic                  clearing;
	logic                  clr_bank;
	logic [IW-1:0]         clr_row;
	logic [OW-1:0]         clr_col;

	assign accept = req.valid && req.ready;
	assign in_ok  = 32'(req.payload.in_channel) < IN_CHANNELS;
	assign out_ok = 32'(req.payload.out_channel) < OUT_CHANNELS;

	assign clr_bank = clr_cnt_q[AW-1];
	assign clr_row  = clr_cnt_q[AW-2:OW];
	assign clr_col  = clr_cnt_q[OW-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			amm_pkg::ST_CLEAR: begin
				if (clr_cnt_q == {AW{1'b1}}) state_d = amm_pkg::ST_IDLE;
			end
			amm_pkg::ST_IDLE: begin
				if (accept && req.payload.mode == amm_pkg::MODE_SAMPLE) begin
					state_d = amm_pkg::ST_MAC;
				end
			end
			amm_pkg::ST_MAC: begin
				if (j_q == LAST_J) state_d = amm_pkg::ST_DRAIN;
			end
			amm_pkg::ST_DRAIN: begin
				if (!mac_req_s1.vld && !mac_busy) begin
					state_d = eof_q ? amm_pkg::ST_EMIT_RD : amm_pkg::ST_IDLE;
				end
			end
			amm_pkg::ST_EMIT_RD: begin
				state_d = amm_pkg::ST_EMIT_LD;
			end
			amm_pkg::ST_EMIT_LD: begin
				if (!out_vld_q || mix.ready) begin
					state_d = (j_q == LAST_J) ? amm_pkg::ST_IDLE : amm_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = amm_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		emit_load = 1'b0;
		clearing  = 1'b0;
		case (state_q)
			amm_pkg::ST_CLEAR:   clearing  = 1'b1;
			amm_pkg::ST_IDLE:    req.ready = 1'b1;
			amm_pkg::ST_MAC:     issue     = 1'b1;
			amm_pkg::ST_EMIT_LD: emit_load = !out_vld_q || mix.ready;
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= amm_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
			j_q       <= '0;
			bank_q    <= 1'b0;
			eof_q     <= 1'b0;
			ic_ok_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_cnt_q <= clr_cnt_q + AW'(1);
			// Swap banks: the old active bank keeps its contents as the new shadow.
			if (accept && req.payload.mode == amm_pkg::MODE_SWAP) bank_q <= !bank_q;
			if (accept && req.payload.mode == amm_pkg::MODE_SAMPLE) begin
				eof_q   <= req.payload.end_of_frame;
				ic_ok_q <= in_ok;
				j_q     <= '0;
			end else if (issue || emit_load) begin
				j_q <= (j_q == LAST_J) ? '0 : j_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.payload.mode == amm_pkg::MODE_SAMPLE) begin
			sample_q <= req.payload.sample;
			ic_q     <= IW'(req.payload.in_channel);
		end
	end

	// Gain banks: one write port for the clearing pass and coefficient loads.
	always_ff @(posedge clk) begin
		if (clearing) begin
			gain_mem[clr_cnt_q] <= (!clr_bank && XW'(clr_row) == XW'(clr_col)) ? UNITY : 32'sd0;
		end else if (accept && req.payload.mode == amm_pkg::MODE_LOAD && in_ok && out_ok) begin
			gain_mem[{!bank_q, IW'(req.payload.in_channel), OW'(req.payload.out_channel)}]
				<= req.payload.gain;
		end
		gain_rd_s1 <= gain_mem[{bank_q, ic_q, j_q}];
	end

	// Accumulators: cleared by the pass, updated by the MAC, zeroed as each result leaves.
	always_ff @(posedge clk) begin
		if (clearing) begin
			acc_mem[clr_col] <= 32'sd0;
		end else if (acc_wr.en) begin
			acc_mem[acc_wr.idx[OW-1:0]] <= acc_wr.data;
		end else if (emit_load) begin
			acc_mem[j_q] <= 32'sd0;
		end
		acc_rd_s1 <= acc_mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_req_s1 <= '0;
		end else begin
			mac_req_s1.vld     <= issue;
			mac_req_s1.path_ok <= ic_ok_q;
			mac_req_s1.idx     <= amm_pkg::CH_IDX_W'(j_q);
		end
	end

	amm_mac #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req_s1 (mac_req_s1),
		.sample (sample_q),
		.gain_s1(gain_rd_s1),
		.acc_s1 (acc_rd_s1),
		.wr     (acc_wr),
		.busy   (mac_busy)
	);

	// Result register: hold while the receiver stalls, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_load) begin
			out_vld_q <= 1'b1;
		end else if (mix.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_q.channel <= 4'(j_q);
			out_q.mixed   <= acc_rd_s1;
			out_q.last    <= (j_q == LAST_J);
		end
	end

	assign mix.valid   = out_vld_q;
	assign mix.payload = out_q;

endmodule

// ===== rtl/core/amm_checker.sv =====
`include "audio_matrix_mixer_defines.svh"

module amm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic [1:0]        req_mode,
	input logic              mix_valid,
	input logic              mix_ready,
	input amm_pkg::amm_out_t mix_payload
);
	`AMM_ASSERT_NEXT(a_mix_hold, clk, arst_n, mix_valid && !mix_ready, mix_valid)
	`AMM_ASSERT_NEXT(a_mix_stable, clk, arst_n, mix_valid && !mix_ready, $stable(mix_payload))
	`AMM_ASSERT_NEXT(a_busy_after_sample, clk, arst_n, req_valid && req_ready && req_mode == amm_pkg::MODE_SAMPLE, !req_ready)
	`AMM_ASSERT_SAME(a_frame_blocks_req, clk, arst_n, mix_valid && !mix_payload.last, !req_ready)
endmodule

bind audio_matrix_mixer amm_checker u_amm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_mode   (req.payload.mode),
	.mix_valid  (mix.valid),
	.mix_ready  (mix.ready),
	.mix_payload(mix.payload)
);
